/* rtl/core/tsrb_pkg.sv */
package tsrb_pkg;

   // field widths fixed by the interface
   localparam int TS_BITS         = 64;
   localparam int COUNT_BITS      = 16;
   localparam int PORT_SAMPLE_BITS = 32;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 17;
   localparam int ANT_CFG_BITS    = 4;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // status codes
   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_NOT_READY = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BUFFER_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NUM_ANTENNAS  = 2'd1;

   // register reset values
   localparam logic [CSR_DATA_BITS-1:0] LENGTH_RESET   = 17'h10000;
   localparam logic [ANT_CFG_BITS-1:0]  ANTENNAS_RESET = 4'd1;

   // remainder unit step counts
   localparam int MOD_STEP_BITS = 7;
   localparam logic [MOD_STEP_BITS-1:0] MOD_STEPS_WIDE  = 7'd64;
   localparam logic [MOD_STEP_BITS-1:0] MOD_STEPS_INDEX = 7'd16;

   typedef struct packed {
      logic                        operation;
      logic [TS_BITS-1:0]          block_timestamp;
      logic [COUNT_BITS-1:0]       block_samples;
      logic [COUNT_BITS-1:0]       element_index;
      logic [PORT_SAMPLE_BITS-1:0] sample_in;
      logic                        block_end;
   } req_type;

   typedef struct packed {
      logic [PORT_SAMPLE_BITS-1:0] sample_out;
      logic                        status;
      logic [TS_BITS-1:0]          consumer_mark;
      logic                        result_last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_GAP_MOD,
      S_GAP_FILL,
      S_ADDR,
      S_BASE_MOD,
      S_IDX_MOD,
      S_ACCESS,
      S_RESP
   } state_type;

   typedef enum logic [1:0] {
      MOD_SRC_TIMESTAMP,
      MOD_SRC_INDEX,
      MOD_SRC_WRITE_END
   } mod_src_type;

   typedef enum logic [1:0] {
      SLOT_SRC_NEXT,
      SLOT_SRC_DIRECT,
      SLOT_SRC_REMAINDER
   } slot_src_type;

   typedef struct packed {
      logic         clear_step;
      logic         load_req;
      logic         decode;
      logic         mod_go;
      mod_src_type  mod_src;
      logic         base_load;
      logic         slot_load;
      slot_src_type slot_src;
      logic         gap_load;
      logic         gap_step;
      logic         access;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic is_read;
      logic idx_zero;
      logic read_blocked;
      logic gap_needed;
      logic gap_last;
      logic mod_done;
      logic seq_hit;
      logic base_hit;
      logic idx_small;
   } sts_type;

endpackage

/* rtl/core/tsrb_mod.sv */
module tsrb_mod #(
   parameter int LENW = 17
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic [tsrb_pkg::TS_BITS-1:0]       dividend,
   input  logic [tsrb_pkg::MOD_STEP_BITS-1:0] steps,
   input  logic [LENW-1:0]                    divisor,
   output logic                               done,
   output logic [LENW-1:0]                    remainder
);

   logic                               run_ff, run_in;
   logic                               done_ff, done_in;
   logic [tsrb_pkg::MOD_STEP_BITS-1:0] cnt_ff, cnt_in;
   logic [tsrb_pkg::TS_BITS-1:0]       shift_ff, shift_in;
   logic [LENW-1:0]                    rem_ff, rem_in;
   logic [LENW:0]                      trial;
   logic [LENW:0]                      diff;

   // one restoring step: bring in the next dividend bit, subtract if it fits
   assign trial = {rem_ff, shift_ff[tsrb_pkg::TS_BITS-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (go) begin
         run_in   = 1'b1;
         cnt_in   = steps;
         shift_in = dividend;
         rem_in   = '0;
      end else if (run_ff) begin
         shift_in = {shift_ff[tsrb_pkg::TS_BITS-2:0], 1'b0};
         rem_in   = (trial >= {1'b0, divisor}) ? diff[LENW-1:0] : trial[LENW-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == 1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* rtl/core/tsrb_datapath.sv */
module tsrb_datapath #(
   parameter int RING_DEPTH   = 65536,
   parameter int SAMPLE_BITS  = 32,
   parameter int MAX_ANTENNAS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  tsrb_pkg::cmd_type                   cmd,
   output tsrb_pkg::sts_type                   sts,
   input  tsrb_pkg::req_type                   req_data,
   output tsrb_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write,
   input  logic [tsrb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsrb_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW   = $clog2(RING_DEPTH);
   localparam int LENW = $clog2(RING_DEPTH + 1);
   localparam int ANTW = $clog2(MAX_ANTENNAS + 1);
   localparam int PRODW = LENW + ANTW;
   localparam int TSW  = tsrb_pkg::TS_BITS;
   localparam int PSW  = tsrb_pkg::PORT_SAMPLE_BITS;

   // clamp a length write into 1..RING_DEPTH
   function automatic logic [LENW-1:0] clamp_len(logic [tsrb_pkg::CSR_DATA_BITS-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         clamp_len = LENW'(1);
      end else if (v32 > 32'(RING_DEPTH)) begin
         clamp_len = LENW'(RING_DEPTH);
      end else begin
         clamp_len = v32[LENW-1:0];
      end
   endfunction

   // clamp an antenna count into 1..MAX_ANTENNAS
   function automatic logic [ANTW-1:0] clamp_ant(logic [tsrb_pkg::ANT_CFG_BITS-1:0] v);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) begin
         clamp_ant = ANTW'(1);
      end else if (v32 > 32'(MAX_ANTENNAS)) begin
         clamp_ant = ANTW'(MAX_ANTENNAS);
      end else begin
         clamp_ant = v32[ANTW-1:0];
      end
   endfunction

   // next slot, wrapping at the ring end
   function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] x, logic [LENW-1:0] len);
      logic [31:0] nxt;
      nxt = 32'(x) + 32'd1;
      wrap_inc = (nxt >= 32'(len)) ? '0 : nxt[AW-1:0];
   endfunction

   // base plus an offset below the length, folded once
   function automatic logic [AW-1:0] fold_add(logic [AW-1:0] b, logic [31:0] x,
                                              logic [LENW-1:0] len);
      logic [31:0] sum;
      sum = 32'(b) + x;
      if (sum >= 32'(len)) begin
         sum = sum - 32'(len);
      end
      fold_add = sum[AW-1:0];
   endfunction

   tsrb_pkg::req_type req_ff;
   logic [LENW-1:0]   len_ff;
   logic [ANTW-1:0]   ant_ff;
   logic [TSW-1:0]    write_end_ff;
   logic [TSW-1:0]    write_marker_ff;
   logic              nr_ff;
   logic              base_valid_ff;
   logic              seq_valid_ff;
   logic [AW-1:0]     clr_ff;
   logic [AW-1:0]     base_ff;
   logic [TSW-1:0]    cache_ts_ff;
   logic [tsrb_pkg::COUNT_BITS-1:0] prev_idx_ff;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [LENW-1:0]   gap_ff;
   logic [AW-1:0]     pos_ff;
   logic [LENW-1:0]   count_ff;
   logic [SAMPLE_BITS-1:0] mem [RING_DEPTH];
   logic [SAMPLE_BITS-1:0] mem_q;

   logic [TSW-1:0]    block_last_ts;
   logic              blocked_now;
   logic [TSW-1:0]    gap_diff;
   logic              gap_needed;
   logic [PRODW-1:0]  gap_prod;
   logic [LENW-1:0]   gap_count;
   logic [31:0]       idx_ext;
   logic              is_read;
   logic [TSW-1:0]    mult_src;
   logic [TSW-1:0]    product;
   logic [TSW-1:0]    dividend;
   logic [tsrb_pkg::MOD_STEP_BITS-1:0] steps;
   logic              mod_done;
   logic [LENW-1:0]   mod_rem;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [SAMPLE_BITS-1:0] mem_wdata;
   logic [SAMPLE_BITS+PSW-1:0] smp_ext;
   logic [SAMPLE_BITS+PSW-1:0] q_ext;

   assign is_read  = (req_ff.operation == tsrb_pkg::OP_READ);
   assign idx_ext  = 32'(req_ff.element_index);
   assign block_last_ts = req_ff.block_timestamp + TSW'(req_ff.block_samples) - TSW'(1);

   // read range check against the last write's start
   assign blocked_now = (write_marker_ff < block_last_ts);

   // gap since the previous write's end
   assign gap_diff   = req_ff.block_timestamp - write_end_ff;
   assign gap_needed = (write_end_ff != '0) && (write_end_ff < req_ff.block_timestamp) &&
                       (gap_diff < TSW'(len_ff));
   assign gap_prod   = PRODW'(gap_ff) * PRODW'(ant_ff);
   assign gap_count  = (gap_prod > PRODW'(len_ff)) ? len_ff : gap_prod[LENW-1:0];

   // shared remainder unit operand select
   always_comb begin
      mult_src = req_ff.block_timestamp;
      dividend = '0;
      steps    = tsrb_pkg::MOD_STEPS_WIDE;
      if (cmd.mod_src == tsrb_pkg::MOD_SRC_WRITE_END) begin
         mult_src = write_end_ff;
      end
      product = mult_src * TSW'(ant_ff);
      unique case (cmd.mod_src)
         tsrb_pkg::MOD_SRC_INDEX: begin
            dividend = {req_ff.element_index, {(TSW - tsrb_pkg::COUNT_BITS){1'b0}}};
            steps    = tsrb_pkg::MOD_STEPS_INDEX;
         end
         default: begin
            dividend = product;
         end
      endcase
   end

   tsrb_mod #(
      .LENW (LENW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .go        (cmd.mod_go),
      .dividend  (dividend),
      .steps     (steps),
      .divisor   (len_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // slot select
   always_comb begin
      slot_in = slot_ff;
      case (cmd.slot_src)
         tsrb_pkg::SLOT_SRC_NEXT:      slot_in = wrap_inc(slot_ff, len_ff);
         tsrb_pkg::SLOT_SRC_DIRECT:    slot_in = fold_add(base_ff, idx_ext, len_ff);
         tsrb_pkg::SLOT_SRC_REMAINDER: slot_in = fold_add(base_ff, 32'(mod_rem), len_ff);
         default:                      slot_in = slot_ff;
      endcase
   end

   // status to the controller
   always_comb begin
      sts.clear_done   = (clr_ff == AW'(RING_DEPTH - 1));
      sts.is_read      = is_read;
      sts.idx_zero     = (req_ff.element_index == '0);
      sts.read_blocked = (req_ff.element_index == '0) ? blocked_now : nr_ff;
      sts.gap_needed   = gap_needed;
      sts.gap_last     = (count_ff == LENW'(1));
      sts.mod_done     = mod_done;
      sts.base_hit     = base_valid_ff && (req_ff.block_timestamp == cache_ts_ff);
      sts.seq_hit      = seq_valid_ff && base_valid_ff &&
                         (req_ff.block_timestamp == cache_ts_ff) &&
                         (idx_ext == 32'(prev_idx_ff) + 32'd1);
      sts.idx_small    = (idx_ext < 32'(len_ff));
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff          <= clamp_len(tsrb_pkg::LENGTH_RESET);
         ant_ff          <= clamp_ant(tsrb_pkg::ANTENNAS_RESET);
         write_end_ff    <= '0;
         write_marker_ff <= '0;
         nr_ff           <= 1'b0;
         base_valid_ff   <= 1'b0;
         seq_valid_ff    <= 1'b0;
         clr_ff          <= '0;
      end else begin
         if (cmd.clear_step) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (cmd.decode && is_read && (req_ff.element_index == '0)) begin
            nr_ff <= blocked_now;
         end
         if (cmd.base_load) begin
            base_valid_ff <= 1'b1;
            seq_valid_ff  <= 1'b0;
         end
         if (cmd.access) begin
            seq_valid_ff <= 1'b1;
            if (!is_read && req_ff.block_end) begin
               write_end_ff    <= req_ff.block_timestamp + TSW'(req_ff.block_samples);
               write_marker_ff <= req_ff.block_timestamp;
            end
         end
         // address mapping changes with either register
         if (csr_write) begin
            unique case (csr_index)
               tsrb_pkg::CSR_BUFFER_LENGTH: begin
                  len_ff        <= clamp_len(csr_data);
                  base_valid_ff <= 1'b0;
                  seq_valid_ff  <= 1'b0;
               end
               tsrb_pkg::CSR_NUM_ANTENNAS: begin
                  ant_ff        <= clamp_ant(csr_data[tsrb_pkg::ANT_CFG_BITS-1:0]);
                  base_valid_ff <= 1'b0;
                  seq_valid_ff  <= 1'b0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // request, cache and gap registers
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.decode) begin
         gap_ff <= gap_diff[LENW-1:0];
      end
      if (cmd.base_load) begin
         base_ff     <= mod_rem[AW-1:0];
         cache_ts_ff <= req_ff.block_timestamp;
      end
      if (cmd.slot_load) begin
         slot_ff <= slot_in;
      end
      if (cmd.access) begin
         prev_idx_ff <= req_ff.element_index;
      end
      if (cmd.gap_load) begin
         pos_ff   <= mod_rem[AW-1:0];
         count_ff <= gap_count;
      end else if (cmd.gap_step) begin
         pos_ff   <= wrap_inc(pos_ff, len_ff);
         count_ff <= count_ff - 1'b1;
      end
   end

   // sample ring write port: clearing, gap zeroing or element write
   assign smp_ext = {{SAMPLE_BITS{1'b0}}, req_ff.sample_in};
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = slot_ff;
      mem_wdata = '0;
      if (cmd.clear_step) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
      end else if (cmd.gap_step) begin
         mem_we    = 1'b1;
         mem_waddr = pos_ff;
      end else if (cmd.access && !is_read) begin
         mem_we    = 1'b1;
         mem_wdata = smp_ext[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.access && is_read) begin
         mem_q <= mem[slot_ff];
      end
   end

   // result payload
   assign q_ext = {{PSW{1'b0}}, mem_q};
   always_comb begin
      rsp_data             = '0;
      rsp_data.result_last = req_ff.block_end;
      rsp_data.status      = tsrb_pkg::STATUS_OK;
      if (is_read) begin
         if (nr_ff) begin
            rsp_data.status = tsrb_pkg::STATUS_NOT_READY;
         end else begin
            rsp_data.sample_out = q_ext[PSW-1:0];
            if (req_ff.block_end) begin
               rsp_data.consumer_mark = block_last_ts;
            end
         end
      end
   end

endmodule

/* rtl/core/tsrb_ctrl.sv */
module tsrb_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  tsrb_pkg::sts_type sts,
   output tsrb_pkg::cmd_type cmd
);

   tsrb_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tsrb_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mod_src  = tsrb_pkg::MOD_SRC_TIMESTAMP;
      cmd.slot_src = tsrb_pkg::SLOT_SRC_NEXT;
      busy         = 1'b1;
      rsp_valid    = 1'b0;
      unique case (state_ff)
         tsrb_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = tsrb_pkg::S_IDLE;
            end
         end
         tsrb_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = tsrb_pkg::S_DECODE;
            end
         end
         tsrb_pkg::S_DECODE: begin
            cmd.decode = 1'b1;
            if (sts.is_read) begin
               state_in = sts.read_blocked ? tsrb_pkg::S_RESP : tsrb_pkg::S_ADDR;
            end else if (sts.idx_zero && sts.gap_needed) begin
               cmd.mod_go  = 1'b1;
               cmd.mod_src = tsrb_pkg::MOD_SRC_WRITE_END;
               state_in    = tsrb_pkg::S_GAP_MOD;
            end else begin
               state_in = tsrb_pkg::S_ADDR;
            end
         end
         tsrb_pkg::S_GAP_MOD: begin
            cmd.mod_src = tsrb_pkg::MOD_SRC_WRITE_END;
            if (sts.mod_done) begin
               cmd.gap_load = 1'b1;
               state_in     = tsrb_pkg::S_GAP_FILL;
            end
         end
         tsrb_pkg::S_GAP_FILL: begin
            cmd.gap_step = 1'b1;
            if (sts.gap_last) begin
               state_in = tsrb_pkg::S_ADDR;
            end
         end
         tsrb_pkg::S_ADDR: begin
            if (sts.seq_hit) begin
               cmd.slot_load = 1'b1;
               cmd.slot_src  = tsrb_pkg::SLOT_SRC_NEXT;
               state_in      = tsrb_pkg::S_ACCESS;
            end else if (sts.base_hit && sts.idx_small) begin
               cmd.slot_load = 1'b1;
               cmd.slot_src  = tsrb_pkg::SLOT_SRC_DIRECT;
               state_in      = tsrb_pkg::S_ACCESS;
            end else if (sts.base_hit) begin
               cmd.mod_go  = 1'b1;
               cmd.mod_src = tsrb_pkg::MOD_SRC_INDEX;
               state_in    = tsrb_pkg::S_IDX_MOD;
            end else begin
               cmd.mod_go  = 1'b1;
               cmd.mod_src = tsrb_pkg::MOD_SRC_TIMESTAMP;
               state_in    = tsrb_pkg::S_BASE_MOD;
            end
         end
         tsrb_pkg::S_BASE_MOD: begin
            if (sts.mod_done) begin
               cmd.base_load = 1'b1;
               state_in      = tsrb_pkg::S_ADDR;
            end
         end
         tsrb_pkg::S_IDX_MOD: begin
            cmd.mod_src = tsrb_pkg::MOD_SRC_INDEX;
            if (sts.mod_done) begin
               cmd.slot_load = 1'b1;
               cmd.slot_src  = tsrb_pkg::SLOT_SRC_REMAINDER;
               state_in      = tsrb_pkg::S_ACCESS;
            end
         end
         tsrb_pkg::S_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = tsrb_pkg::S_RESP;
         end
         tsrb_pkg::S_RESP: begin
            rsp_valid = 1'b1;
            busy      = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = tsrb_pkg::S_DECODE;
            end else begin
               state_in = tsrb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tsrb_pkg::S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/timestamped_sample_ring_buffer.sv */
// Timestamp-addressed sample ring. One transaction is one write or read element.
// Input: an element is taken at a clock edge with start high and busy low.
// Output: one result per element, shown for a single cycle with rsp_valid high;
// the receiver cannot stall, so it must take every result in that cycle.
// Configuration: csr_valid/csr_ready write channel, always ready; write only
// while no element is in flight.
// Reset: synchronous; afterwards the ring is zeroed one slot per cycle,
// all RING_DEPTH slots, with busy high (register writes are still taken).
// Path, from accept edge to result strobe: decode, address, access, result
//   states for the next element of the same block (index one past the last);
//   a changed block timestamp adds a base pass of the remainder unit (bit-serial,
//   one quotient bit per cycle over the 64-bit timestamp product);
//   an index not below the ring length adds an index pass of that unit;
//   a write start that zero-fills a gap adds a pass on the last write end and
//   a fill of gap*antennas slots, the zeroed stretch capped at the ring length;
//   a read refused as not ready goes from decode straight to the result.
// A new element is taken in the result cycle, so elements stream back to back
// with no idle state between them.
module timestamped_sample_ring_buffer #(
   parameter int RING_DEPTH   = 65536,
   parameter int SAMPLE_BITS  = 32,
   parameter int MAX_ANTENNAS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  tsrb_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   output tsrb_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tsrb_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tsrb_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   tsrb_pkg::cmd_type cmd;
   tsrb_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   // sequencer
   tsrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   // ring, address arithmetic and registers
   tsrb_datapath #(
      .RING_DEPTH   (RING_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS),
      .MAX_ANTENNAS (MAX_ANTENNAS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // an accepted element keeps the block busy in the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted element did not make the block busy");

   // a result only follows a cycle of work
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without preceding work");

   // a refused read carries no sample and no consumer mark
   a_not_ready_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == tsrb_pkg::STATUS_NOT_READY)) |->
      ((rsp_data.sample_out == '0) && (rsp_data.consumer_mark == '0)))
      else $error("not-ready result carries data");

endmodule

/* tb/tb_timestamped_sample_ring_buffer.sv */
`timescale 1ns / 1ps

// predicts every element result of the ring and checks the block against it
class sample_ring_model;
   localparam int RING_SLOTS = 65536;
   localparam int MAX_ANT    = 8;

   logic [31:0]       ring [RING_SLOTS];
   logic [63:0]       write_end;
   logic [63:0]       write_marker;
   bit                hold_not_ready;
   logic [16:0]       length_reg;
   logic [3:0]        antenna_reg;
   tsrb_pkg::rsp_type element_results[$];
   int                errors;
   int                checked;
   int                writes;
   int                reads;
   int                refused;
   int                fills;

   function new();
      foreach (ring[i]) ring[i] = '0;
      write_end      = '0;
      write_marker   = '0;
      hold_not_ready = 1'b0;
      length_reg     = tsrb_pkg::LENGTH_RESET;
      antenna_reg    = tsrb_pkg::ANTENNAS_RESET;
      errors         = 0;
      checked        = 0;
      writes         = 0;
      reads          = 0;
      refused        = 0;
      fills          = 0;
   endfunction

   function void configure(logic [tsrb_pkg::CSR_INDEX_BITS-1:0] index,
                           logic [tsrb_pkg::CSR_DATA_BITS-1:0] value);
      if (index == tsrb_pkg::CSR_BUFFER_LENGTH) begin
         length_reg = value;
      end else if (index == tsrb_pkg::CSR_NUM_ANTENNAS) begin
         antenna_reg = value[3:0];
      end
   endfunction

   // out-of-range settings clamp to the nearest legal value
   function logic [63:0] length_in_use();
      if (length_reg == 0) return 64'd1;
      if (length_reg > RING_SLOTS) return 64'(RING_SLOTS);
      return 64'(length_reg);
   endfunction

   function logic [63:0] antennas_in_use();
      if (antenna_reg == 0) return 64'd1;
      if (antenna_reg > MAX_ANT) return 64'(MAX_ANT);
      return 64'(antenna_reg);
   endfunction

   function logic [63:0] slot_of(logic [63:0] ts, logic [15:0] idx);
      logic [63:0] len;
      logic [63:0] base;
      len  = length_in_use();
      base = (ts * antennas_in_use()) % len;
      return (base + 64'(idx)) % len;
   endfunction

   // work out the result of one accepted element and update the ring
   function void take_element(tsrb_pkg::req_type e);
      tsrb_pkg::rsp_type r;
      logic [63:0]       len;
      logic [63:0]       ant;
      logic [63:0]       block_last_ts;
      logic [63:0]       gap;
      logic [63:0]       count;
      logic [63:0]       pos;
      logic [63:0]       slot;
      len           = length_in_use();
      ant           = antennas_in_use();
      block_last_ts = e.block_timestamp + 64'(e.block_samples) - 64'd1;
      r             = '0;
      r.result_last = e.block_end;
      slot          = slot_of(e.block_timestamp, e.element_index);
      if (e.operation == tsrb_pkg::OP_WRITE) begin
         writes++;
         // zero the stretch between the last write and this block start
         if (e.element_index == 0 && write_end != 0 && write_end < e.block_timestamp) begin
            gap = e.block_timestamp - write_end;
            if (gap < len) begin
               fills++;
               count = gap * ant;
               if (count > len) count = len;
               pos = (write_end * ant) % len;
               for (int i = 0; i < count; i++) begin
                  ring[pos[15:0]] = '0;
                  pos++;
                  if (pos >= len) pos = '0;
               end
            end
         end
         ring[slot[15:0]] = e.sample_in;
         if (e.block_end) begin
            write_end    = e.block_timestamp + 64'(e.block_samples);
            write_marker = e.block_timestamp;
         end
      end else begin
         reads++;
         // the verdict is taken on the first element and held for the rest
         if (e.element_index == 0) hold_not_ready = (write_marker < block_last_ts);
         if (hold_not_ready) begin
            refused++;
            r.status = tsrb_pkg::STATUS_NOT_READY;
         end else begin
            r.status     = tsrb_pkg::STATUS_OK;
            r.sample_out = ring[slot[15:0]];
            if (e.block_end) r.consumer_mark = block_last_ts;
         end
      end
      element_results.push_back(r);
   endfunction

   function void report(string what, tsrb_pkg::rsp_type want, tsrb_pkg::rsp_type got);
      errors++;
      if (errors <= 10) begin
         $display({"%s: expected sample %h status %0d mark %h last %0d,",
                   " got sample %h status %0d mark %h last %0d"},
                  what, want.sample_out, want.status, want.consumer_mark, want.result_last,
                  got.sample_out, got.status, got.consumer_mark, got.result_last);
      end
   endfunction

   // compare one result transaction with the oldest prediction
   function void match_answer(tsrb_pkg::rsp_type got);
      tsrb_pkg::rsp_type want;
      checked++;
      if (element_results.size() == 0) begin
         report("result with nothing pending", '0, got);
         return;
      end
      want = element_results.pop_front();
      if (got.sample_out !== want.sample_out || got.status !== want.status ||
          got.consumer_mark !== want.consumer_mark || got.result_last !== want.result_last) begin
         report("result mismatch", want, got);
      end
   endfunction

   function void close_out();
      if (element_results.size() != 0) begin
         errors += element_results.size();
         $display("%0d predicted results never arrived", element_results.size());
      end
   endfunction
endclass

module tb_timestamped_sample_ring_buffer;

   localparam int     ITEMS_PER_PHASE = 125;
   localparam int     PHASES          = 8;
   localparam longint CYCLE_LIMIT     = 2000000;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   tsrb_pkg::req_type                   req_data;
   logic                                rsp_valid;
   tsrb_pkg::rsp_type                   rsp_data;
   logic                                csr_valid;
   logic                                csr_ready;
   logic [tsrb_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [tsrb_pkg::CSR_DATA_BITS-1:0]  csr_data;

   sample_ring_model model;
   longint           cycle_count = 0;
   bit               burst;
   int               sent;

   // ring settings walked through, extremes and out-of-range values included
   logic [16:0] ring_lengths [PHASES] = '{17'h10000, 17'd16, 17'd0, 17'h1FFFF,
                                          17'd100, 17'd1, 17'd4097, 17'h10000};
   logic [3:0]  ring_antennas [PHASES] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd5, 4'd8};

   timestamped_sample_ring_buffer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) model.match_answer(rsp_data);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL timestamped_sample_ring_buffer");
         $finish;
      end
   end

   // write both ring registers back to back, valid held across both
   task automatic set_ring(input logic [16:0] len, input logic [3:0] ant);
      csr_valid <= 1'b1;
      csr_index <= tsrb_pkg::CSR_BUFFER_LENGTH;
      csr_data  <= len;
      do @(posedge clock); while (!csr_ready);
      model.configure(tsrb_pkg::CSR_BUFFER_LENGTH, len);
      csr_index <= tsrb_pkg::CSR_NUM_ANTENNAS;
      csr_data  <= {13'd0, ant};
      do @(posedge clock); while (!csr_ready);
      model.configure(tsrb_pkg::CSR_NUM_ANTENNAS, {13'd0, ant});
      csr_valid <= 1'b0;
   endtask

   function automatic tsrb_pkg::req_type make_element(logic op, logic [63:0] ts,
                                                      logic [15:0] ns, logic [15:0] idx,
                                                      logic [31:0] smp, logic last);
      tsrb_pkg::req_type e;
      e.operation       = op;
      e.block_timestamp = ts;
      e.block_samples   = ns;
      e.element_index   = idx;
      e.sample_in       = smp;
      e.block_end       = last;
      return e;
   endfunction

   // drive one element transaction and wait for it to be taken
   task automatic send_element(input tsrb_pkg::req_type e);
      int pause;
      pause = burst ? 0 : $urandom_range(0, 15);
      if (pause != 0) begin
         start <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= e;
      do @(posedge clock); while (busy);
      model.take_element(e);
      sent++;
   endtask

   // one block, optionally missing its first elements or its end marker
   task automatic run_block(input logic op, input logic [63:0] ts, input logic [15:0] ns,
                            input int first, input bit drop_end);
      int count;
      count = int'(64'(ns) * model.antennas_in_use());
      burst = ($urandom_range(0, 3) == 0);
      for (int i = first; i < count; i++) begin
         send_element(make_element(op, ts, ns, 16'(i), $urandom,
                                   (i == count - 1) && !drop_end));
      end
   endtask

   task automatic directed();
      // first write, then a second one past a gap that gets zeroed
      run_block(tsrb_pkg::OP_WRITE, 64'd10, 16'd4, 0, 1'b0);
      run_block(tsrb_pkg::OP_WRITE, 64'd20, 16'd2, 0, 1'b0);
      run_block(tsrb_pkg::OP_READ, 64'd10, 16'd4, 0, 1'b0);
      // read beyond the written range
      run_block(tsrb_pkg::OP_READ, 64'd30, 16'd2, 0, 1'b0);
      // later read element reuses the verdict of an earlier first element
      run_block(tsrb_pkg::OP_READ, 64'd10, 16'd1, 0, 1'b1);
      send_element(make_element(tsrb_pkg::OP_READ, 64'd11, 16'd1, 16'd2, 32'd0, 1'b1));
      // zero sample count, read end wraps
      send_element(make_element(tsrb_pkg::OP_READ, 64'd0, 16'd0, 16'd0, 32'd0, 1'b1));
      send_element(make_element(tsrb_pkg::OP_READ, 64'd5, 16'd0, 16'd0, 32'd0, 1'b1));
      // field extremes, end sums wrap
      send_element(make_element(tsrb_pkg::OP_WRITE, '1, 16'hFFFF, 16'hFFFF,
                                32'hFFFF_FFFF, 1'b1));
      send_element(make_element(tsrb_pkg::OP_READ, '1, 16'hFFFF, 16'hFFFF, 32'd0, 1'b1));
      send_element(make_element(tsrb_pkg::OP_WRITE, 64'd0, 16'd1, 16'd0, 32'd0, 1'b0));
      // long gap clears most of the ring
      send_element(make_element(tsrb_pkg::OP_WRITE, 64'd100000, 16'd1, 16'd0,
                                32'h1234_5678, 1'b1));
      send_element(make_element(tsrb_pkg::OP_READ, 64'd100000, 16'd1, 16'd0, 32'd0, 1'b1));
      send_element(make_element(tsrb_pkg::OP_READ, 64'd99999, 16'd2, 16'hFFFF, 32'd0, 1'b1));
   endtask

   // mostly well-formed write and read blocks near the write front, plus noise
   task automatic random_phase(input int items);
      int          kind;
      int          stop_at;
      int          skip;
      logic        op;
      logic [63:0] ts;
      logic [15:0] ns;
      stop_at = sent + items;
      if ($urandom_range(0, 1) == 1) begin
         run_block(tsrb_pkg::OP_WRITE, {$urandom, $urandom}, 16'($urandom_range(1, 4)),
                   0, 1'b0);
      end
      while (sent < stop_at) begin
         kind = $urandom_range(0, 99);
         ns   = 16'($urandom_range(1, 4));
         if (kind < 40) begin
            ts = model.write_end + 64'($urandom_range(0, 5));
            run_block(tsrb_pkg::OP_WRITE, ts, ns, 0, 1'b0);
         end else if (kind < 75) begin
            ts = model.write_marker - 64'($urandom_range(0, 10));
            run_block(tsrb_pkg::OP_READ, ts, ns, 0, 1'b0);
         end else if (kind < 88) begin
            // broken block: start skipped or end dropped
            op   = kind[0] ? tsrb_pkg::OP_WRITE : tsrb_pkg::OP_READ;
            ts   = (op == tsrb_pkg::OP_WRITE) ?
                   model.write_end + 64'($urandom_range(0, 5)) :
                   model.write_marker - 64'($urandom_range(0, 10));
            skip = $urandom_range(0, 1);
            run_block(op, ts, ns, skip, skip ? bit'($urandom_range(0, 1)) : 1'b1);
         end else begin
            burst = ($urandom_range(0, 3) == 0);
            send_element(make_element(logic'($urandom_range(0, 1)), {$urandom, $urandom},
                                      16'($urandom), 16'($urandom), $urandom,
                                      logic'($urandom_range(0, 1))));
         end
      end
   endtask

   // let every predicted result come back before touching the registers
   task automatic settle();
      start <= 1'b0;
      while (model.element_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data  = '0;
      sent      = 0;
      burst     = 1'b0;
      model     = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int p = 0; p < PHASES; p++) begin
         set_ring(ring_lengths[p], ring_antennas[p]);
         if (p == 0) begin
            directed();
            settle();
         end
         random_phase(ITEMS_PER_PHASE);
         settle();
      end

      repeat (200) @(posedge clock);
      model.close_out();
      $display("sent %0d elements: %0d writes, %0d reads (%0d refused), %0d gap fills",
               sent, model.writes, model.reads, model.refused, model.fills);
      $display("%0d ring settings, %0d results checked, %0d errors",
               PHASES, model.checked, model.errors);
      if (model.errors == 0) begin
         $display("PASS timestamped_sample_ring_buffer");
      end else begin
         $display("FAIL timestamped_sample_ring_buffer");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/tsrb_pkg.sv
rtl/core/tsrb_mod.sv
rtl/core/tsrb_datapath.sv
rtl/core/tsrb_ctrl.sv
rtl/core/timestamped_sample_ring_buffer.sv
tb/tb_timestamped_sample_ring_buffer.sv
